>>> rtl/oaht_pkg.sv
// Package for the open addressing hash table: types, constants and the prime table.
package oaht_pkg;

  localparam int DEF_MAX_SHIFT   = 10;
  localparam int DEF_MIN_SHIFT   = 3;
  localparam int DEF_KEY_WIDTH   = 64;
  localparam int DEF_VALUE_WIDTH = 32;
  localparam int HASH_WIDTH      = 32;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_DONE     = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  localparam logic [HASH_WIDTH-1:0] HASH_EMPTY = 32'd0;
  localparam logic [HASH_WIDTH-1:0] HASH_TOMB  = 32'd1;
  localparam logic [HASH_WIDTH-1:0] HASH_MIN   = 32'd2;

  typedef enum logic [3:0] {
    S_WIPE, S_IDLE, S_MOD, S_READ, S_WAIT, S_CHECK, S_WRITE, S_FIN, S_CLEAR, S_OUT
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture the accepted item
    logic mod_start;  // begin the modulo
    logic probe_init; // first slot from the remainder
    logic step;       // advance the probe
    logic wr;         // perform the write decided by the request
    logic wipe;       // write empty at the wipe index
    logic wipe_start; // reset the wipe index
    logic finish;     // form the result
  } cmd_t;

  typedef struct packed {
    logic mod_done;
    logic stop;      // probe ended (empty, hit or exhausted)
    logic need_wr;   // the request changes the store
    logic wipe_last;
  } sts_t;

  function automatic logic [16:0] prime_for(input logic [4:0] s);
    case (s)
      5'd0: prime_for = 17'd1;     5'd1: prime_for = 17'd2;
      5'd2: prime_for = 17'd3;     5'd3: prime_for = 17'd7;
      5'd4: prime_for = 17'd13;    5'd5: prime_for = 17'd31;
      5'd6: prime_for = 17'd61;    5'd7: prime_for = 17'd127;
      5'd8: prime_for = 17'd251;   5'd9: prime_for = 17'd509;
      5'd10: prime_for = 17'd1021; 5'd11: prime_for = 17'd2039;
      5'd12: prime_for = 17'd4093; 5'd13: prime_for = 17'd8191;
      5'd14: prime_for = 17'd16381; 5'd15: prime_for = 17'd32749;
      5'd16: prime_for = 17'd65521;
      default: prime_for = 17'd1;
    endcase
  endfunction

  // Reciprocal of each prime scaled by 2^32, rounded down. The quotient it
  // gives is the true one or one less.
  function automatic logic [31:0] recip_for(input logic [4:0] s);
    case (s)
      5'd0: recip_for = 32'hFFFF_FFFF;   5'd1: recip_for = 32'd2147483648;
      5'd2: recip_for = 32'd1431655765;  5'd3: recip_for = 32'd613566756;
      5'd4: recip_for = 32'd330382099;   5'd5: recip_for = 32'd138547332;
      5'd6: recip_for = 32'd70409299;    5'd7: recip_for = 32'd33818640;
      5'd8: recip_for = 32'd17111423;    5'd9: recip_for = 32'd8438049;
      5'd10: recip_for = 32'd4206628;    5'd11: recip_for = 32'd2106408;
      5'd12: recip_for = 32'd1049344;    5'd13: recip_for = 32'd524352;
      5'd14: recip_for = 32'd262192;     5'd15: recip_for = 32'd131148;
      5'd16: recip_for = 32'd65551;
      default: recip_for = 32'hFFFF_FFFF;
    endcase
  endfunction

endpackage

>>> rtl/oaht_ram.sv
// Generic single port RAM with registered read.
module oaht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

>>> rtl/oaht_mod.sv
// Modulo unit: 32-bit dividend by a 17-bit prime through a scaled reciprocal: multiply, multiply back, correct.
module oaht_mod import oaht_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [HASH_WIDTH-1:0] dividend,
  input  logic [16:0]           divisor,
  input  logic [31:0]           recip,
  output logic                  done,
  output logic [16:0]           rem
);
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_BACK = 2'd2;
  localparam logic [1:0] PH_FIX  = 2'd3;

  logic [1:0] phase_r, phase_nxt;
  logic [HASH_WIDTH-1:0] quo_r, quo_nxt;
  logic [HASH_WIDTH-1:0] part_r, part_nxt;
  logic [16:0] rem_r, rem_nxt;
  logic [2*HASH_WIDTH-1:0] prod;
  logic [HASH_WIDTH+16:0] back;

  // The dividend and divisor are read only after start, once they are held.
  always_comb begin
    phase_nxt = phase_r; quo_nxt = quo_r; part_nxt = part_r; rem_nxt = rem_r;
    prod = (2*HASH_WIDTH)'(dividend) * (2*HASH_WIDTH)'(recip);
    back = (HASH_WIDTH+17)'(quo_r) * (HASH_WIDTH+17)'(divisor);
    if (start) begin
      phase_nxt = PH_MUL;
    end else begin
      case (phase_r)
        PH_MUL: begin
          quo_nxt = prod[2*HASH_WIDTH-1:HASH_WIDTH]; phase_nxt = PH_BACK;
        end
        PH_BACK: begin
          part_nxt = dividend - back[HASH_WIDTH-1:0]; phase_nxt = PH_FIX;
        end
        PH_FIX: begin
          rem_nxt = (part_r >= HASH_WIDTH'(divisor)) ?
                    17'(part_r - HASH_WIDTH'(divisor)) : part_r[16:0];
          phase_nxt = PH_IDLE;
        end
        default: phase_nxt = PH_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
    end else begin
      phase_r <= phase_nxt;
    end
    quo_r <= quo_nxt; part_r <= part_nxt; rem_r <= rem_nxt;
  end

  assign done = phase_r == PH_IDLE && !start;
  assign rem  = rem_r;
endmodule

>>> rtl/oaht_ctrl.sv
// Controller state machine for the hash table.
module oaht_ctrl import oaht_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  output logic out_valid,
  input  logic out_ready,
  input  logic [1:0] kind,
  input  sts_t sts,
  output cmd_t cmd
);
  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_WIPE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r; cmd = '0;
    in_ready = 1'b0; out_valid = 1'b0;
    case (state_r)
      S_WIPE: begin
        cmd.wipe = 1'b1;
        if (sts.wipe_last) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load = 1'b1;
          if (kind == KIND_CLEAR) begin
            cmd.wipe_start = 1'b1; state_nxt = S_CLEAR;
          end else begin
            cmd.mod_start = 1'b1; state_nxt = S_MOD;
          end
        end
      end
      S_MOD: if (sts.mod_done) begin
        cmd.probe_init = 1'b1; state_nxt = S_READ;
      end
      S_READ: state_nxt = S_WAIT;
      S_WAIT: state_nxt = S_CHECK;
      S_CHECK: begin
        cmd.step = 1'b1;
        if (sts.stop) state_nxt = sts.need_wr ? S_WRITE : S_FIN;
        else state_nxt = S_READ;
      end
      S_WRITE: begin cmd.wr = 1'b1; cmd.finish = 1'b1; state_nxt = S_OUT; end
      S_FIN: begin cmd.finish = 1'b1; state_nxt = S_OUT; end
      S_CLEAR: begin
        cmd.wipe = 1'b1;
        if (sts.wipe_last) begin cmd.finish = 1'b1; state_nxt = S_OUT; end
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end
endmodule

>>> rtl/oaht_dp.sv
// Datapath: slot memories, probe logic, counters and result registers.
module oaht_dp import oaht_pkg::*; #(
  parameter int MAX_SHIFT   = DEF_MAX_SHIFT,
  parameter int MIN_SHIFT   = DEF_MIN_SHIFT,
  parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic clk,
  input  logic rst_n,
  input  cmd_t cmd,
  output sts_t sts,
  input  logic [3:0] shift_cfg,
  input  logic [1:0] in_kind,
  input  logic [KEY_WIDTH-1:0] in_key,
  input  logic [HASH_WIDTH-1:0] in_hash,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic found,
  output logic [VALUE_WIDTH-1:0] read_value,
  output logic [MAX_SHIFT-1:0] slot_index,
  output logic [1:0] status,
  output logic [MAX_SHIFT:0] live_count,
  output logic [MAX_SHIFT:0] occupied_count,
  output logic resize_wanted
);
  localparam int DEPTH = 1 << MAX_SHIFT;
  localparam int AW = MAX_SHIFT;
  localparam int CW = MAX_SHIFT + 1;

  logic [1:0] kind_r;
  logic [KEY_WIDTH-1:0] key_r;
  logic [HASH_WIDTH-1:0] hash_r;
  logic [VALUE_WIDTH-1:0] val_r;
  logic [4:0] shift_r;
  logic [AW-1:0] idx_r, tomb_r, last_r, wipe_r;
  logic [CW-1:0] n_r, live_r, occ_r;
  logic have_tomb_r, hit_r, empty_r;
  logic [AW-1:0] mask;

  logic [4:0] eff;
  always_comb begin
    eff = {1'b0, shift_cfg};
    if (eff < 5'(MIN_SHIFT)) eff = 5'(MIN_SHIFT);
    if (eff > 5'(MAX_SHIFT)) eff = 5'(MAX_SHIFT);
  end
  assign mask = AW'(({{(CW-1){1'b0}}, 1'b1} << shift_r) - 1'b1);

  logic mod_done;
  logic [16:0] rem;
  oaht_mod u_mod (
    .clk, .rst_n, .start(cmd.mod_start), .dividend(hash_r),
    .divisor(prime_for(shift_r)), .recip(recip_for(shift_r)), .done(mod_done), .rem
  );

  logic [HASH_WIDTH-1:0] rd_hash, wr_hash;
  logic [KEY_WIDTH-1:0] rd_key;
  logic [VALUE_WIDTH-1:0] rd_val, wr_val;
  logic we_h, we_kv, we_v;
  logic [AW-1:0] addr;

  // Probe outcome of the slot just read.
  logic is_empty, is_hit, is_tomb, exhausted, stop;
  assign is_empty  = rd_hash == HASH_EMPTY;
  assign is_hit    = rd_hash == hash_r && rd_key == key_r;
  assign is_tomb   = rd_hash == HASH_TOMB;
  assign exhausted = (n_r + 1'b1) == ({{(CW-1){1'b0}}, 1'b1} << shift_r);
  assign stop      = is_empty || is_hit || exhausted;

  logic f_hit, f_empty, f_tomb;
  logic [AW-1:0] f_tomb_idx;
  assign f_hit      = is_hit;
  assign f_empty    = is_empty;
  assign f_tomb     = have_tomb_r || (is_tomb && !is_empty && !is_hit);
  assign f_tomb_idx = have_tomb_r ? tomb_r : idx_r;

  logic ins_new, ins_empty;
  assign ins_new   = kind_r == KIND_INSERT && !hit_r && (have_tomb_r || empty_r);
  assign ins_empty = !have_tomb_r;

  always_comb begin
    addr = idx_r; we_h = 1'b0; we_kv = 1'b0; we_v = 1'b0;
    wr_hash = hash_r; wr_val = val_r;
    if (cmd.wipe) begin
      addr = wipe_r; we_h = 1'b1; wr_hash = HASH_EMPTY;
    end else if (cmd.wr) begin
      if (kind_r == KIND_REMOVE) begin
        addr = last_r; we_h = 1'b1; wr_hash = HASH_TOMB;
      end else if (hit_r) begin
        addr = last_r; we_v = 1'b1;
      end else begin
        addr = have_tomb_r ? tomb_r : last_r;
        we_h = 1'b1; we_kv = 1'b1; we_v = 1'b1;
      end
    end
  end

  oaht_ram #(.WIDTH(HASH_WIDTH), .DEPTH(DEPTH)) u_hash (
    .clk, .we(we_h), .addr, .wdata(wr_hash), .rdata(rd_hash));
  oaht_ram #(.WIDTH(KEY_WIDTH), .DEPTH(DEPTH)) u_key (
    .clk, .we(we_kv), .addr, .wdata(key_r), .rdata(rd_key));
  oaht_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(DEPTH)) u_val (
    .clk, .we(we_v), .addr, .wdata(wr_val), .rdata(rd_val));

  logic [VALUE_WIDTH-1:0] hit_val_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      live_r <= '0; occ_r <= '0; wipe_r <= '0;
      found <= 1'b0; read_value <= '0; slot_index <= '0; status <= ST_DONE;
    end else begin
      if (cmd.wipe_start) wipe_r <= '0;
      else if (cmd.wipe) wipe_r <= wipe_r + 1'b1;
      if (cmd.load && in_kind == KIND_CLEAR) begin
        live_r <= '0; occ_r <= '0;
      end
      if (cmd.wr) begin
        if (kind_r == KIND_REMOVE) begin
          if (live_r != '0) live_r <= live_r - 1'b1;
        end else if (!hit_r) begin
          live_r <= live_r + 1'b1;
          if (ins_empty) occ_r <= occ_r + 1'b1;
        end
      end
      if (cmd.finish) begin
        found <= 1'b0; read_value <= '0; status <= ST_DONE; slot_index <= '0;
        if (kind_r != KIND_CLEAR) begin
          found <= hit_r;
          slot_index <= ins_new ? (have_tomb_r ? tomb_r : last_r) : last_r;
          if (kind_r == KIND_LOOKUP && hit_r) read_value <= hit_val_r;
          if (kind_r == KIND_INSERT) begin
            if (!hit_r && !have_tomb_r && !empty_r) status <= ST_FULL;
          end else if (!hit_r) status <= ST_NOTFOUND;
        end
      end
    end
    if (cmd.load) begin
      kind_r <= in_kind; key_r <= in_key; val_r <= in_value; shift_r <= eff;
      hash_r <= (in_hash <= HASH_TOMB) ? HASH_MIN : in_hash;
    end
    if (cmd.probe_init) begin
      idx_r <= AW'(rem) & mask; n_r <= '0; have_tomb_r <= 1'b0;
      hit_r <= 1'b0; empty_r <= 1'b0;
    end
    if (cmd.step) begin
      last_r <= idx_r; hit_r <= f_hit; empty_r <= f_empty; hit_val_r <= rd_val;
      have_tomb_r <= f_tomb; tomb_r <= f_tomb_idx;
      idx_r <= (idx_r + AW'(n_r) + 1'b1) & mask;
      n_r <= n_r + 1'b1;
    end
  end

  // Result fields are formed from values settled before finish; hit flags and
  // tomb index used at finish are the registered ones written in the check step.
  logic need_wr;
  assign need_wr = (kind_r == KIND_INSERT && (f_hit || f_tomb || f_empty)) ||
                   (kind_r == KIND_REMOVE && f_hit);

  assign sts.mod_done  = mod_done;
  assign sts.stop      = stop;
  assign sts.need_wr   = need_wr;
  assign sts.wipe_last = wipe_r == AW'(DEPTH - 1);

  logic [CW+2:0] size_w, live4, occ_sum;
  assign size_w  = (CW+3)'({{(CW-1){1'b0}}, 1'b1} << shift_r);
  assign live4   = {1'b0, live_r, 2'b00};
  assign occ_sum = (CW+3)'(occ_r) + (CW+3)'(occ_r >> 4);
  assign live_count     = live_r;
  assign occupied_count = occ_r;
  assign resize_wanted  = (size_w > live4 && size_w > (CW+3)'(1 << MIN_SHIFT)) ||
                          (size_w <= occ_sum);
endmodule

>>> rtl/open_addressing_hash_table_unit.sv
// Top level of the open addressing hash table unit.
// One request is taken at a time. A lookup, insert or remove first forms the
// hash modulo (reciprocal multiply, multiply back, one correcting subtract,
// then the first probe index), then probes slots in turn, each by memory read,
// registered data and compare, then writes the store where the request calls
// for it and forms the result, and then offers the result. A clear, and the
// pass that follows reset, sweep all 2^MAX_SHIFT entries of the slot hash
// memory one entry per cycle, during which no item is accepted.
module open_addressing_hash_table_unit import oaht_pkg::*; #(
  parameter int MAX_SHIFT   = DEF_MAX_SHIFT,
  parameter int MIN_SHIFT   = DEF_MIN_SHIFT,
  parameter int KEY_WIDTH   = DEF_KEY_WIDTH,
  parameter int VALUE_WIDTH = DEF_VALUE_WIDTH
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic [3:0] cfg_size_shift,
  input  logic in_valid,
  output logic in_ready,
  input  logic [1:0] in_kind,
  input  logic [KEY_WIDTH-1:0] in_key,
  input  logic [HASH_WIDTH-1:0] in_key_hash,
  input  logic [VALUE_WIDTH-1:0] in_new_value,
  output logic out_valid,
  input  logic out_ready,
  output logic out_found,
  output logic [VALUE_WIDTH-1:0] out_read_value,
  output logic [MAX_SHIFT-1:0] out_slot_index,
  output logic [1:0] out_status,
  output logic [MAX_SHIFT:0] out_live_count,
  output logic [MAX_SHIFT:0] out_occupied_count,
  output logic out_resize_wanted
);
  logic [3:0] size_shift_r;
  always_ff @(posedge clk) begin
    if (!rst_n) size_shift_r <= 4'd3;
    else if (cfg_we) size_shift_r <= cfg_size_shift;
  end

  cmd_t cmd;
  sts_t sts;

  oaht_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .out_valid, .out_ready,
    .kind(in_kind), .sts, .cmd
  );

  oaht_dp #(
    .MAX_SHIFT(MAX_SHIFT), .MIN_SHIFT(MIN_SHIFT),
    .KEY_WIDTH(KEY_WIDTH), .VALUE_WIDTH(VALUE_WIDTH)
  ) u_dp (
    .clk, .rst_n, .cmd, .sts, .shift_cfg(size_shift_r),
    .in_kind, .in_key, .in_hash(in_key_hash), .in_value(in_new_value),
    .found(out_found), .read_value(out_read_value), .slot_index(out_slot_index),
    .status(out_status), .live_count(out_live_count),
    .occupied_count(out_occupied_count), .resize_wanted(out_resize_wanted)
  );

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input taken while result pending");
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status != 2'd3) else $error("bad status code");
  a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_found) |-> out_status == ST_DONE) else $error("found with error");
  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_live_count <= out_occupied_count) else $error("live above occupied");
endmodule

>>> tb/open_addressing_hash_table_unit_tb.sv
// Testbench for the open addressing hash table unit: table-driven and random requests.
module open_addressing_hash_table_unit_tb;
  import oaht_pkg::*;

  localparam int DEPTH = 1 << DEF_MAX_SHIFT;
  localparam int STALL_LIMIT = 50000;

  typedef struct {
    logic found;
    logic [31:0] read_value;
    logic [9:0] slot;
    logic [1:0] status;
    logic [10:0] live;
    logic [10:0] occupied;
    logic resize;
    bit pinned;
    logic [1:0] pin_status;
    logic pin_found;
  } reply_t;

  typedef struct {
    kind_t kind;
    logic [63:0] key;
    logic [31:0] hash;
    logic [31:0] value;
    bit pinned;
    status_t status;
    logic found;
  } row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [3:0] cfg_size_shift = 4'd3;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [1:0] in_kind = KIND_LOOKUP;
  logic [63:0] in_key = '0;
  logic [31:0] in_key_hash = '0;
  logic [31:0] in_new_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_found;
  logic [31:0] out_read_value;
  logic [9:0] out_slot_index;
  logic [1:0] out_status;
  logic [10:0] out_live_count;
  logic [10:0] out_occupied_count;
  logic out_resize_wanted;

  // Shadow copy of the table and its configuration.
  logic [31:0] tbl_hash [DEPTH];
  logic [63:0] tbl_key [DEPTH];
  logic [31:0] tbl_value [DEPTH];
  int unsigned tbl_live;
  int unsigned tbl_occupied;
  logic [3:0] tbl_shift;
  int unsigned primes [17] = '{1, 2, 3, 7, 13, 31, 61, 127, 251, 509, 1021,
                              2039, 4093, 8191, 16381, 32749, 65521};

  reply_t replies_q [$];
  row_t rows [$];
  bit drv_pinned = 0;
  status_t drv_status = ST_DONE;
  logic drv_found = 1'b0;
  bit calm = 0;
  int errors = 0;
  int idle_cycles = 0;
  int kind_count [4] = '{0, 0, 0, 0};
  int full_count = 0;
  int miss_count = 0;
  int hit_count = 0;

  logic [63:0] pool_key [24];
  logic [31:0] pool_hash [24];

  open_addressing_hash_table_unit dut (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_size_shift(cfg_size_shift),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind), .in_key(in_key),
    .in_key_hash(in_key_hash), .in_new_value(in_new_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_found(out_found),
    .out_read_value(out_read_value), .out_slot_index(out_slot_index),
    .out_status(out_status), .out_live_count(out_live_count),
    .out_occupied_count(out_occupied_count), .out_resize_wanted(out_resize_wanted)
  );

  always #5 clk = ~clk;

  function automatic void wipe_table();
    for (int i = 0; i < DEPTH; i++) tbl_hash[i] = HASH_EMPTY;
    tbl_live = 0;
    tbl_occupied = 0;
  endfunction

  // Works out the reply to one request and applies it to the shadow table.
  function automatic reply_t apply_request(logic [1:0] kind, logic [63:0] key,
                                           logic [31:0] hash, logic [31:0] value);
    reply_t r;
    int unsigned shift, size, mask, idx, last, tomb, t;
    bit have_tomb, hit, hit_empty;
    logic [31:0] h;
    shift = tbl_shift < DEF_MIN_SHIFT ? DEF_MIN_SHIFT :
            (tbl_shift > DEF_MAX_SHIFT ? DEF_MAX_SHIFT : tbl_shift);
    size = 1 << shift;
    mask = size - 1;
    h = (hash <= HASH_TOMB) ? HASH_MIN : hash;
    have_tomb = 0; hit = 0; hit_empty = 0; last = 0; tomb = 0;
    r.found = 0; r.read_value = '0; r.slot = '0; r.status = ST_DONE;
    r.pinned = 0; r.pin_status = ST_DONE; r.pin_found = 0;
    if (kind == KIND_CLEAR) begin
      wipe_table();
    end else begin
      idx = (h % primes[shift]) & mask;
      for (int n = 0; n < size; n++) begin
        last = idx;
        if (tbl_hash[idx] == HASH_EMPTY) begin
          hit_empty = 1;
          break;
        end
        if (tbl_hash[idx] == h && tbl_key[idx] == key) begin
          hit = 1;
          break;
        end
        if (tbl_hash[idx] == HASH_TOMB && !have_tomb) begin
          tomb = idx;
          have_tomb = 1;
        end
        idx = (idx + n + 1) & mask;
      end
      r.slot = 10'(last);
      if (kind == KIND_INSERT) begin
        if (hit) begin
          r.found = 1;
          tbl_value[last] = value;
        end else if (have_tomb || hit_empty) begin
          t = have_tomb ? tomb : last;
          if (tbl_hash[t] == HASH_EMPTY) tbl_occupied++;
          tbl_hash[t] = h;
          tbl_key[t] = key;
          tbl_value[t] = value;
          tbl_live++;
          r.slot = 10'(t);
        end else begin
          r.status = ST_FULL;
        end
      end else if (hit) begin
        r.found = 1;
        if (kind == KIND_LOOKUP) begin
          r.read_value = tbl_value[last];
        end else begin
          tbl_hash[last] = HASH_TOMB;
          if (tbl_live > 0) tbl_live--;
        end
      end else begin
        r.status = ST_NOTFOUND;
      end
    end
    r.live = 11'(tbl_live);
    r.occupied = 11'(tbl_occupied);
    r.resize = (size > tbl_live * 4 && size > (1 << DEF_MIN_SHIFT)) ||
               (size <= tbl_occupied + tbl_occupied / 16);
    return r;
  endfunction

  // Requests are predicted as they are accepted; replies are checked as they leave.
  always @(posedge clk) begin
    reply_t r;
    reply_t e;
    if (rst_n && in_valid && in_ready) begin
      r = apply_request(in_kind, in_key, in_key_hash, in_new_value);
      r.pinned = drv_pinned;
      r.pin_status = drv_status;
      r.pin_found = drv_found;
      replies_q.push_back(r);
      kind_count[in_kind]++;
      if (r.status == ST_FULL) full_count++;
      if (r.status == ST_NOTFOUND) miss_count++;
      if (r.found) hit_count++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (replies_q.size() == 0) begin
        $display("%0t: reply with nothing outstanding (status %0d)", $time, out_status);
        errors++;
      end else begin
        e = replies_q.pop_front();
        if (e.pinned && (e.pin_status != out_status || e.pin_found != out_found)) begin
          $display("%0t: status/found expected %0d/%0d, got %0d/%0d", $time,
                   e.pin_status, e.pin_found, out_status, out_found);
          errors++;
        end
        if (out_found !== e.found) begin
          $display("%0t: found expected %0d, got %0d", $time, e.found, out_found);
          errors++;
        end
        if (out_read_value !== e.read_value) begin
          $display("%0t: read_value expected %h, got %h", $time, e.read_value,
                   out_read_value);
          errors++;
        end
        if (out_slot_index !== e.slot) begin
          $display("%0t: slot_index expected %0d, got %0d", $time, e.slot, out_slot_index);
          errors++;
        end
        if (out_status !== e.status) begin
          $display("%0t: status expected %0d, got %0d", $time, e.status, out_status);
          errors++;
        end
        if (out_live_count !== e.live) begin
          $display("%0t: live_count expected %0d, got %0d", $time, e.live, out_live_count);
          errors++;
        end
        if (out_occupied_count !== e.occupied) begin
          $display("%0t: occupied_count expected %0d, got %0d", $time, e.occupied,
                   out_occupied_count);
          errors++;
        end
        if (out_resize_wanted !== e.resize) begin
          $display("%0t: resize_wanted expected %0d, got %0d", $time, e.resize,
                   out_resize_wanted);
          errors++;
        end
      end
    end
  end

  // The watchdog trips when neither channel moves an item for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
      $display("** open_addressing_hash_table_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  always @(negedge clk) begin
    out_ready <= calm ? 1'b1 : ($urandom_range(99) >= 33);
  end

  // Valid stays up after an item is taken until the next send or a drain lowers it;
  // the block is busy then, so nothing is taken twice.
  task automatic send(logic [1:0] kind, logic [63:0] key, logic [31:0] hash,
                      logic [31:0] value, bit pinned, status_t st, logic found);
    if (!calm && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_key <= key;
    in_key_hash <= hash;
    in_new_value <= value;
    drv_pinned <= pinned;
    drv_status <= st;
    drv_found <= found;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Waits for every outstanding reply, then lets the block settle.
  task automatic drain();
    in_valid <= 1'b0;
    while (replies_q.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic set_shift(logic [3:0] s);
    drain();
    cfg_we <= 1'b1;
    cfg_size_shift <= s;
    tbl_shift = s;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic add_row(kind_t kind, logic [63:0] key, logic [31:0] hash,
                         logic [31:0] value, bit pinned, status_t st, logic found);
    row_t r;
    r.kind = kind; r.key = key; r.hash = hash; r.value = value;
    r.pinned = pinned; r.status = st; r.found = found;
    rows.push_back(r);
  endtask

  initial begin
    logic [3:0] phase_shift [8] = '{4'd5, 4'd0, 4'd15, 4'd4, 4'd3, 4'd10, 4'd7, 4'd6};
    int p, pick, roll;
    logic [1:0] kind;
    logic [63:0] key;
    logic [31:0] hash;
    tbl_shift = 4'd3;
    wipe_table();
    for (int i = 0; i < 24; i++) begin
      pool_key[i] = {$urandom, $urandom};
      // A few pool entries share hashes or use the reserved hash values.
      pool_hash[i] = (i < 4) ? i[31:0] % 2 : ((i % 5 == 0) ? 32'h1234 : $urandom);
    end
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Size 8, prime 7: fill the table, overflow it, then use the tombstone.
    add_row(KIND_LOOKUP, '0, '0, '0, 1, ST_NOTFOUND, 0);
    add_row(KIND_INSERT, '1, '1, '1, 1, ST_DONE, 0);
    add_row(KIND_LOOKUP, '1, '1, '0, 1, ST_DONE, 1);
    add_row(KIND_INSERT, 64'd1, 32'd1, '0, 1, ST_DONE, 0);
    for (int i = 2; i < 8; i++) begin
      add_row(KIND_INSERT, 64'(i), 32'd5 * 32'(i), 32'(i), 0, ST_DONE, 0);
    end
    add_row(KIND_INSERT, 64'd100, 32'd9, 32'd7, 1, ST_FULL, 0);
    add_row(KIND_INSERT, '1, '1, '0, 1, ST_DONE, 1);
    add_row(KIND_REMOVE, 64'd1, 32'd1, '0, 1, ST_DONE, 1);
    add_row(KIND_REMOVE, 64'd1, 32'd1, '0, 1, ST_NOTFOUND, 0);
    add_row(KIND_LOOKUP, 64'd1, 32'd0, '0, 1, ST_NOTFOUND, 0);
    add_row(KIND_INSERT, 64'd100, 32'd9, 32'h8000_0001, 1, ST_DONE, 0);
    add_row(KIND_LOOKUP, 64'd100, 32'd9, '0, 0, ST_DONE, 0);
    add_row(KIND_CLEAR, '1, '1, '1, 1, ST_DONE, 0);
    add_row(KIND_LOOKUP, '1, '1, '0, 1, ST_NOTFOUND, 0);
    foreach (rows[i]) begin
      send(rows[i].kind, rows[i].key, rows[i].hash, rows[i].value,
           rows[i].pinned, rows[i].status, rows[i].found);
    end

    // Random phases, each under a size set at its start; some change size without a clear.
    for (p = 0; p < 8; p++) begin
      set_shift(phase_shift[p]);
      calm = (p == 3);
      if (p % 3 == 0) send(KIND_CLEAR, '0, '0, '0, 0, ST_DONE, 0);
      for (int n = 0; n < 125; n++) begin
        roll = $urandom_range(99);
        kind = roll < 45 ? KIND_INSERT : (roll < 75 ? KIND_LOOKUP :
               (roll < 98 ? KIND_REMOVE : KIND_CLEAR));
        if ($urandom_range(9) == 0) begin
          key = {$urandom, $urandom};
          hash = $urandom;
        end else begin
          pick = $urandom_range(23);
          key = pool_key[pick];
          hash = pool_hash[pick];
        end
        send(kind, key, hash, $urandom, 0, ST_DONE, 0);
      end
    end
    calm = 0;
    set_shift(4'd3);
    drain();

    $display("Requests: %0d lookup, %0d insert, %0d remove, %0d clear over sizes 8..1024.",
             kind_count[KIND_LOOKUP], kind_count[KIND_INSERT], kind_count[KIND_REMOVE],
             kind_count[KIND_CLEAR]);
    $display("Outcomes: %0d hits, %0d misses, %0d inserts refused as full.",
             hit_count, miss_count, full_count);
    if (errors == 0) begin
      $display("** open_addressing_hash_table_unit: PASSED **");
    end else begin
      $display("** open_addressing_hash_table_unit: FAILED **");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/oaht_pkg.sv
rtl/oaht_ram.sv
rtl/oaht_mod.sv
rtl/oaht_ctrl.sv
rtl/oaht_dp.sv
rtl/open_addressing_hash_table_unit.sv
tb/open_addressing_hash_table_unit_tb.sv
